@@ rtl/core/skc_pkg.sv @@
// ----------------------------------------------------------------------------
// skc_pkg
// Shared widths, types and helpers for the quintic spline kernel pipeline.
// ----------------------------------------------------------------------------
package skc_pkg;

    localparam int QSQ_W   = 20;
    localparam int DIST_W  = 32;
    localparam int OUT_W   = 32;
    localparam int CFG_W   = 32;
    localparam int ROOT_W  = 18;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int MAG_W   = 57;
    localparam int G_W     = MAG_W + 1;
    localparam int SAT_W   = 66;
    localparam int LATENCY = 87;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_SCALE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_SCALE = 1'b1;

    localparam logic [CFG_W-1:0] VALUE_SCALE_RST    = 32'h0100_0000;
    localparam logic [CFG_W-1:0] GRADIENT_SCALE_RST = 32'hFF00_0000;

    localparam logic [ROOT_W-1:0] ONE_Q16   = 18'd65536;
    localparam logic [ROOT_W-1:0] TWO_Q16   = 18'd131072;
    localparam logic [ROOT_W-1:0] THREE_Q16 = 18'd196608;

    typedef struct packed {
        logic signed [DIST_W-1:0] x;
        logic signed [DIST_W-1:0] y;
        logic signed [DIST_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [OUT_W-1:0] weight;
        logic                    grad_zero;
        logic                    neg;
        t_vec                    vec;
    } t_div_tag;

    function automatic logic [OUT_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(64'sh0000_0000_7FFF_FFFF);
        lo = -SAT_W'(64'sh0000_0000_8000_0000);
        if (v > hi) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end else begin
            return v[OUT_W-1:0];
        end
    endfunction

endpackage

@@ rtl/core/skc_sqrt.sv @@
// ----------------------------------------------------------------------------
// skc_sqrt
// Pipelined integer square root, one root bit per stage, tag carried along.
// ----------------------------------------------------------------------------
module skc_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [skc_pkg::QSQ_W-1:0]    i_qsq,
    input  skc_pkg::t_vec                i_vec,
    output logic                         o_valid,
    output logic [skc_pkg::ROOT_W-1:0]   o_root,
    output skc_pkg::t_vec                o_vec
);
    import skc_pkg::*;

    logic              r_valid [ROOT_W];
    logic [RAD_W-1:0]  r_rad   [ROOT_W];
    logic [REM_W-1:0]  r_rem   [ROOT_W];
    logic [ROOT_W-1:0] r_root  [ROOT_W];
    t_vec              r_vec   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_st
        logic              s_valid;
        logic [RAD_W-1:0]  s_rad;
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        t_vec              s_vec;
        logic [REM_W-1:0]  cand;
        logic [REM_W-1:0]  sub;
        logic              ge;

        if (k == 0) begin : g_in
            assign s_valid = i_valid;
            assign s_rad   = {i_qsq, {(RAD_W-QSQ_W){1'b0}}};
            assign s_rem   = '0;
            assign s_root  = '0;
            assign s_vec   = i_vec;
        end else begin : g_mid
            assign s_valid = r_valid[k-1];
            assign s_rad   = r_rad[k-1];
            assign s_rem   = r_rem[k-1];
            assign s_root  = r_root[k-1];
            assign s_vec   = r_vec[k-1];
        end

        assign cand = {s_rem[REM_W-3:0], s_rad[RAD_W-1 -: 2]};
        assign sub  = {1'b0, s_root, 2'b01};
        assign ge   = (cand >= sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= s_valid;
            end
            r_rad[k]  <= {s_rad[RAD_W-3:0], 2'b00};
            r_rem[k]  <= ge ? (cand - sub) : cand;
            r_root[k] <= {s_root[ROOT_W-2:0], ge};
            r_vec[k]  <= s_vec;
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_vec   = r_vec[ROOT_W-1];

endmodule

@@ rtl/core/skc_div.sv @@
// ----------------------------------------------------------------------------
// skc_div
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
// ----------------------------------------------------------------------------
module skc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [skc_pkg::MAG_W-1:0]    i_dividend,
    input  logic [skc_pkg::ROOT_W-1:0]   i_divisor,
    input  skc_pkg::t_div_tag            i_tag,
    output logic                         o_valid,
    output logic [skc_pkg::MAG_W-1:0]    o_quot,
    output skc_pkg::t_div_tag            o_tag
);
    import skc_pkg::*;

    logic              r_valid [MAG_W];
    logic [MAG_W-1:0]  r_work  [MAG_W];
    logic [ROOT_W-1:0] r_rem   [MAG_W];
    logic [ROOT_W-1:0] r_dvs   [MAG_W];
    t_div_tag          r_tag   [MAG_W];

    for (genvar k = 0; k < MAG_W; k++) begin : g_st
        logic              s_valid;
        logic [MAG_W-1:0]  s_work;
        logic [ROOT_W-1:0] s_rem;
        logic [ROOT_W-1:0] s_dvs;
        t_div_tag          s_tag;
        logic [ROOT_W:0]   cand;
        logic [ROOT_W:0]   diff;
        logic              ge;

        if (k == 0) begin : g_in
            assign s_valid = i_valid;
            assign s_work  = i_dividend;
            assign s_rem   = '0;
            assign s_dvs   = i_divisor;
            assign s_tag   = i_tag;
        end else begin : g_mid
            assign s_valid = r_valid[k-1];
            assign s_work  = r_work[k-1];
            assign s_rem   = r_rem[k-1];
            assign s_dvs   = r_dvs[k-1];
            assign s_tag   = r_tag[k-1];
        end

        assign cand = {s_rem, s_work[MAG_W-1]};
        assign ge   = (cand >= {1'b0, s_dvs});
        assign diff = cand - {1'b0, s_dvs};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= s_valid;
            end
            r_work[k] <= {s_work[MAG_W-2:0], ge};
            r_rem[k]  <= ge ? diff[ROOT_W-1:0] : cand[ROOT_W-1:0];
            r_dvs[k]  <= s_dvs;
            r_tag[k]  <= s_tag;
        end
    end

    assign o_valid = r_valid[MAG_W-1];
    assign o_quot  = r_work[MAG_W-1];
    assign o_tag   = r_tag[MAG_W-1];

endmodule

@@ rtl/core/sph_quintic_kernel_eval.sv @@
// ----------------------------------------------------------------------------
// sph_quintic_kernel_eval
// Quintic spline kernel value and gradient for one particle pair per word.
// ----------------------------------------------------------------------------
// Takes one word per clock (busy never rises) and returns its result on a
// one-cycle o_valid strobe; the receiver cannot stall. The pipeline holds
// the 18-stage square root and the 57-stage divider that forms
// gradient_scale*S4/q, one bit per stage. Write the scale registers
// only while no word is in flight.
module sph_quintic_kernel_eval (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [skc_pkg::QSQ_W-1:0]          i_dist_squared,
    input  logic signed [skc_pkg::DIST_W-1:0]  i_dist_x,
    input  logic signed [skc_pkg::DIST_W-1:0]  i_dist_y,
    input  logic signed [skc_pkg::DIST_W-1:0]  i_dist_z,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [skc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [skc_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                               o_valid,
    output logic signed [skc_pkg::OUT_W-1:0]   o_weight,
    output logic signed [skc_pkg::OUT_W-1:0]   o_grad_x,
    output logic signed [skc_pkg::OUT_W-1:0]   o_grad_y,
    output logic signed [skc_pkg::OUT_W-1:0]   o_grad_z
);
    import skc_pkg::*;

    logic [CFG_W-1:0]        r_vscale;
    logic signed [CFG_W-1:0] r_gscale;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vscale <= VALUE_SCALE_RST;
            r_gscale <= GRADIENT_SCALE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_VALUE_SCALE: begin
                    r_vscale <= i_cfg_data;
                end
                REG_GRADIENT_SCALE: begin
                    r_gscale <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    logic             r0_valid;
    logic [QSQ_W-1:0] r0_qsq;
    t_vec             r0_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start && !busy;
        end
        r0_qsq <= i_dist_squared;
        r0_vec <= '{x: i_dist_x, y: i_dist_y, z: i_dist_z};
    end

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_vec              sq_vec;

    skc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_valid),
        .i_qsq   (r0_qsq),
        .i_vec   (r0_vec),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_vec   (sq_vec)
    );

    // bases 3-q, 2-q, 1-q, zero once not positive
    logic              r1_valid, r1_gz;
    logic [ROOT_W-1:0] r1_qf;
    logic [ROOT_W-1:0] r1_base [3];
    t_vec              r1_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= sq_valid;
        end
        r1_qf      <= sq_root;
        r1_gz      <= (sq_root == '0) || (sq_root >= THREE_Q16);
        r1_base[0] <= (sq_root < THREE_Q16) ? THREE_Q16 - sq_root : '0;
        r1_base[1] <= (sq_root < TWO_Q16)   ? TWO_Q16 - sq_root   : '0;
        r1_base[2] <= (sq_root < ONE_Q16)   ? ONE_Q16 - sq_root   : '0;
        r1_vec     <= sq_vec;
    end

    logic              r2_valid, r2_gz, r3_valid, r3_gz, r4_valid, r4_gz;
    logic [ROOT_W-1:0] r2_qf, r3_qf, r4_qf;
    t_vec              r2_vec, r3_vec, r4_vec;
    logic [ROOT_W-1:0] r2_base [3];
    logic [ROOT_W-1:0] r3_base [3];
    logic [19:0]       r2_p2   [3];
    logic [22:0]       r3_p4   [3];
    logic [22:0]       r4_p4   [3];
    logic [23:0]       r4_p5   [3];

    for (genvar i = 0; i < 3; i++) begin : g_pow
        logic [2*ROOT_W-1:0] sq;
        logic [39:0]         p4w;
        logic [40:0]         p5w;

        assign sq  = r1_base[i] * r1_base[i];
        assign p4w = r2_p2[i] * r2_p2[i];
        assign p5w = r3_p4[i] * r3_base[i];

        always_ff @(posedge i_clk) begin
            r2_p2[i]   <= sq[35:16];
            r2_base[i] <= r1_base[i];
            r3_p4[i]   <= p4w[38:16];
            r3_base[i] <= r2_base[i];
            r4_p4[i]   <= r3_p4[i];
            r4_p5[i]   <= p5w[39:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
        r2_gz  <= r1_gz;
        r3_gz  <= r2_gz;
        r4_gz  <= r3_gz;
        r2_qf  <= r1_qf;
        r3_qf  <= r2_qf;
        r4_qf  <= r3_qf;
        r2_vec <= r1_vec;
        r3_vec <= r2_vec;
        r4_vec <= r3_vec;
    end

    // spline sums
    localparam logic signed [26:0] K6  = 27'sd6;
    localparam logic signed [26:0] K15 = 27'sd15;

    logic               r5_valid, r5_gz;
    logic [ROOT_W-1:0]  r5_qf;
    t_vec               r5_vec;
    logic signed [25:0] r5_s4;
    logic signed [26:0] r5_s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_gz  <= r4_gz;
        r5_qf  <= r4_qf;
        r5_vec <= r4_vec;
        r5_s4  <= $signed({3'b000, r4_p4[0]})
                - $signed({3'b000, r4_p4[1]}) * K6[25:0]
                + $signed({3'b000, r4_p4[2]}) * K15[25:0];
        r5_s5  <= $signed({3'b000, r4_p5[0]})
                - $signed({3'b000, r4_p5[1]}) * K6
                + $signed({3'b000, r4_p5[2]}) * K15;
    end

    // scale products
    logic               r6_valid, r6_gz;
    logic [ROOT_W-1:0]  r6_qf;
    t_vec               r6_vec;
    logic signed [59:0] r6_w;
    logic signed [57:0] r6_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
        r6_gz  <= r5_gz;
        r6_qf  <= r5_qf;
        r6_vec <= r5_vec;
        r6_w   <= $signed({1'b0, r_vscale}) * r5_s5;
        r6_t   <= r_gscale * r5_s4;
    end

    // weight saturation, split T into sign and magnitude
    logic               r7_valid;
    logic [MAG_W-1:0]   r7_tmag;
    logic [ROOT_W-1:0]  r7_qf;
    t_div_tag           r7_tag;
    logic signed [57:0] t_abs;

    assign t_abs = r6_t[57] ? -r6_t : r6_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else begin
            r7_valid <= r6_valid;
        end
        r7_tmag           <= t_abs[MAG_W-1:0];
        r7_qf             <= r6_qf;
        r7_tag.weight     <= sat32(SAT_W'($signed(r6_w[59:24])));
        r7_tag.grad_zero  <= r6_gz;
        r7_tag.neg        <= r6_t[57];
        r7_tag.vec        <= r6_vec;
    end

    logic             dv_valid;
    logic [MAG_W-1:0] dv_quot;
    t_div_tag         dv_tag;

    skc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r7_valid),
        .i_dividend (r7_tmag),
        .i_divisor  (r7_qf),
        .i_tag      (r7_tag),
        .o_valid    (dv_valid),
        .o_quot     (dv_quot),
        .o_tag      (dv_tag)
    );

    // signed G
    logic               r8_valid;
    logic signed [G_W-1:0] r8_g;
    t_div_tag           r8_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else begin
            r8_valid <= dv_valid;
        end
        r8_g   <= dv_tag.neg ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
        r8_tag <= dv_tag;
    end

    // G * component as two partial products, then sum and saturate
    logic                    r9_valid, r10_valid;
    t_div_tag                r9_tag, r10_tag;
    logic signed [DIST_W-1:0] comp [3];
    logic signed [61:0]      r9_lo  [3];
    logic signed [60:0]      r9_hi  [3];
    logic signed [89:0]      r10_pr [3];
    logic [OUT_W-1:0]        grad   [3];

    assign comp[0] = r8_tag.vec.x;
    assign comp[1] = r8_tag.vec.y;
    assign comp[2] = r8_tag.vec.z;

    for (genvar i = 0; i < 3; i++) begin : g_grad
        always_ff @(posedge i_clk) begin
            r9_lo[i]  <= $signed({1'b0, r8_g[28:0]}) * comp[i];
            r9_hi[i]  <= $signed(r8_g[G_W-1:29]) * comp[i];
            r10_pr[i] <= $signed({r9_hi[i], 29'b0}) + 90'(r9_lo[i]);
        end
        assign grad[i] = r10_tag.grad_zero ? '0 : sat32(r10_pr[i][89:24]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_valid  <= 1'b0;
            r10_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r9_valid  <= r8_valid;
            r10_valid <= r9_valid;
            o_valid   <= r10_valid;
        end
        r9_tag   <= r8_tag;
        r10_tag  <= r9_tag;
        o_weight <= r10_tag.weight;
        o_grad_x <= grad[0];
        o_grad_y <= grad[1];
        o_grad_z <= grad[2];
    end

endmodule

@@ rtl/core/skc_check.sv @@
// ----------------------------------------------------------------------------
// skc_check
// Port-level checks on timing and special cases of the kernel pipeline.
// ----------------------------------------------------------------------------
module skc_check (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [skc_pkg::QSQ_W-1:0]          i_dist_squared,
    input logic                               o_valid,
    input logic signed [skc_pkg::OUT_W-1:0]   o_weight,
    input logic signed [skc_pkg::OUT_W-1:0]   o_grad_x,
    input logic signed [skc_pkg::OUT_W-1:0]   o_grad_y,
    input logic signed [skc_pkg::OUT_W-1:0]   o_grad_z
);
    import skc_pkg::*;

    localparam logic [QSQ_W-1:0] SUPPORT_END = 20'd589824;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("result word missing at fixed latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result word without an accepted word");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_dist_squared == '0) |-> ##LATENCY
        (o_valid && o_grad_x == '0 && o_grad_y == '0 && o_grad_z == '0))
        else $error("gradient not zero at zero distance");

    a_support: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_dist_squared >= SUPPORT_END) |-> ##LATENCY
        (o_valid && o_weight == '0 && o_grad_x == '0 && o_grad_y == '0
         && o_grad_z == '0))
        else $error("nonzero result beyond kernel support");

endmodule

bind sph_quintic_kernel_eval skc_check u_skc_check (.*);

@@ verif/sph_quintic_kernel_eval_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sph_quintic_kernel_eval_tb
// Drives q^2 and distance words into the kernel pipeline, predicts the spline
// weight and gradient in fixed point, and checks every strobed result in order
// across several scale settings and sender idle rates.
// ----------------------------------------------------------------------------
module sph_quintic_kernel_eval_tb;
    import skc_pkg::*;

    localparam longint unsigned Q1 = 65536;
    localparam longint unsigned GRAD_CAP = 64'h0100_0000_0000_0000;

    typedef struct {
        logic [QSQ_W-1:0]         qsq;
        logic signed [DIST_W-1:0] dx;
        logic signed [DIST_W-1:0] dy;
        logic signed [DIST_W-1:0] dz;
    } t_pair;

    typedef struct {
        logic [OUT_W-1:0] w;
        logic [OUT_W-1:0] gx;
        logic [OUT_W-1:0] gy;
        logic [OUT_W-1:0] gz;
    } t_kernel;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [QSQ_W-1:0]         i_dist_squared;
    logic signed [DIST_W-1:0] i_dist_x;
    logic signed [DIST_W-1:0] i_dist_y;
    logic signed [DIST_W-1:0] i_dist_z;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     o_valid;
    logic signed [OUT_W-1:0]  o_weight;
    logic signed [OUT_W-1:0]  o_grad_x;
    logic signed [OUT_W-1:0]  o_grad_y;
    logic signed [OUT_W-1:0]  o_grad_z;

    t_pair   pair_q[$];
    t_kernel kernel_q[$];
    longint unsigned val_scale;
    longint          grd_scale;
    int              idle_pct;
    int              err_cnt;

    sph_quintic_kernel_eval i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic logic [OUT_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] grad_part(longint g, logic signed [DIST_W-1:0] d);
        longint          v;
        longint unsigned mg;
        longint unsigned mv;
        logic            neg;
        longint          prod;
        v = d;
        neg = (g < 0) != (v < 0);
        mg = g < 0 ? -g : g;
        mv = v < 0 ? -v : v;
        if (mg == 0 || mv == 0) return '0;
        if (mg > GRAD_CAP / mv) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        prod = mg * mv;
        if (neg) prod = -prod;
        return clamp32(prod >>> 24);
    endfunction

    function automatic t_kernel spline_eval(t_pair p);
        t_kernel         r;
        longint unsigned qf;
        longint unsigned base;
        longint unsigned p2;
        longint unsigned p4;
        longint unsigned p5;
        longint          s4;
        longint          s5;
        longint          g;
        s4 = 0;
        s5 = 0;
        qf = root_floor(longint'(p.qsq) << 16);
        for (int k = 3; k >= 1; k--) begin
            if (qf < k * Q1) begin
                base = k * Q1 - qf;
                p2 = (base * base) >> 16;
                p4 = (p2 * p2) >> 16;
                p5 = (p4 * base) >> 16;
                s4 += (k == 3 ? 1 : k == 2 ? -6 : 15) * longint'(p4);
                s5 += (k == 3 ? 1 : k == 2 ? -6 : 15) * longint'(p5);
            end
        end
        r.w = clamp32((longint'(val_scale) * s5) >>> 24);
        if (qf == 0 || qf >= 3 * Q1) begin
            r.gx = '0;
            r.gy = '0;
            r.gz = '0;
        end else begin
            g = (grd_scale * s4) / longint'(qf);
            r.gx = grad_part(g, p.dx);
            r.gy = grad_part(g, p.dy);
            r.gz = grad_part(g, p.dz);
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_pair nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                kernel_q.push_back(spline_eval('{i_dist_squared, i_dist_x, i_dist_y,
                                                 i_dist_z}));
            end
            if (pair_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pair_q.pop_front();
                start <= 1'b1;
                i_dist_squared <= nxt.qsq;
                i_dist_x <= nxt.dx;
                i_dist_y <= nxt.dy;
                i_dist_z <= nxt.dz;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic report(string nm, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] got);
        if (exp_v !== got) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("%0t %s mismatch: expected %h, got %h", $realtime, nm, exp_v, got);
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_kernel e;
        if (i_rst_n && o_valid) begin
            if (kernel_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("%0t unexpected result word", $realtime);
            end else begin
                e = kernel_q.pop_front();
                report("weight", e.w, o_weight);
                report("grad_x", e.gx, o_grad_x);
                report("grad_y", e.gy, o_grad_y);
                report("grad_z", e.gz, o_grad_z);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_VALUE_SCALE) val_scale = data;
        else grd_scale = longint'(signed'(data));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pair_q.size() != 0 || start || kernel_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic signed [DIST_W-1:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1: return 0;
            2: return $signed(32'($urandom_range(255))) - 128;
            3: return $signed(32'($urandom_range(1 << 20))) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [QSQ_W-1:0]         qsq_set[];
        logic signed [DIST_W-1:0] vec_set[];
        logic [CFG_W-1:0]         vs_set[];
        logic [CFG_W-1:0]         gs_set[];
        int                       idle_set[];
        t_pair                    p;
        qsq_set = '{0, 1, 2, 65535, 65536, 65537, 262143,
                    262144, 589823, 589824, 589825, 1048575};
        vec_set = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh0001_0000};
        vs_set = '{32'hFFFF_FFFF, 0, 32'h0100_0000, $urandom, 32'h0ABC_1234};
        gs_set = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFF00_0000, $urandom};
        idle_set = '{0, 74, 30, 0, 74};
        err_cnt = 0;
        idle_pct = 0;
        val_scale = 64'h0100_0000;
        grd_scale = -64'sh0100_0000;
        start = 1'b0;
        i_dist_squared = '0;
        i_dist_x = '0;
        i_dist_y = '0;
        i_dist_z = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_VALUE_SCALE;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset scales
        foreach (qsq_set[k])
            pair_q.push_back('{qsq_set[k], vec_set[k % 6], vec_set[(k + 1) % 6],
                               vec_set[(k + 3) % 6]});
        foreach (vec_set[k])
            pair_q.push_back('{QSQ_W'(1000 * (k + 1)), vec_set[k], vec_set[5 - k],
                               -vec_set[k]});
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_VALUE_SCALE, vs_set[ph]);
            write_reg(REG_GRADIENT_SCALE, gs_set[ph]);
            idle_pct = idle_set[ph];
            for (int n = 0; n < 200; n++) begin
                case ($urandom_range(9))
                    0: p.qsq = QSQ_W'($urandom);
                    1: p.qsq = QSQ_W'($urandom_range(64));
                    default: p.qsq = QSQ_W'($urandom_range(589824));
                endcase
                p.dx = rand_comp();
                p.dy = rand_comp();
                p.dz = rand_comp();
                pair_q.push_back(p);
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/skc_pkg.sv
rtl/core/skc_sqrt.sv
rtl/core/skc_div.sv
rtl/core/sph_quintic_kernel_eval.sv
rtl/core/skc_check.sv
verif/sph_quintic_kernel_eval_tb.sv
